// File: rtl/core/tbp_pkg.sv
// Shared types, constants and counter helpers for the tournament branch predictor.
`default_nettype none

package tbp_pkg;

   localparam int BIMODAL_ENTRIES_DEF = 1024;
   localparam int GSHARE_ENTRIES_DEF  = 1024;
   localparam int CHOOSER_ENTRIES_DEF = 1024;
   localparam int HISTORY_BITS_DEF    = 10;

   localparam int PC_W       = 32;
   localparam int WORD_W     = 30;
   localparam int SNAP_W     = 10;
   localparam int HIST_OUT_W = 10;

   localparam int PIPE_STAGES = 4;
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int OCC_W       = $clog2(RSP_DEPTH + 1);

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_INIT = 2'd1;
   localparam ctr_type CTR_MAX  = 2'd3;
   localparam ctr_type CTR_MIN  = 2'd0;

   typedef enum logic {
      CMD_PREDICT = 1'b0,
      CMD_UPDATE  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                 command;
      logic                    branch_taken;
      logic                    bimodal_guess;
      logic                    gshare_guess;
      logic [HIST_OUT_W-1:0]   history_now;
   } item_type;

   typedef struct packed {
      logic                    predicted_taken;
      logic                    bimodal_taken;
      logic                    gshare_taken;
      logic [HIST_OUT_W-1:0]   history_now;
   } rsp_beat_type;

   function automatic ctr_type ctr_inc(input ctr_type c);
      return (c == CTR_MAX) ? c : c + 2'd1;
   endfunction

   function automatic ctr_type ctr_dec(input ctr_type c);
      return (c == CTR_MIN) ? c : c - 2'd1;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/tbp_if.sv
// Request and response channel interfaces of the tournament branch predictor.
`default_nettype none

interface tbp_req_if
   import tbp_pkg::*;
();
   logic                valid;
   logic                ready;
   cmd_type             command;
   logic [PC_W-1:0]     pc;
   logic                branch_taken;
   logic [SNAP_W-1:0]   history_snapshot;
   logic                bimodal_guess;
   logic                gshare_guess;
   logic                mispredicted;

   modport source (
      output valid, command, pc, branch_taken, history_snapshot,
             bimodal_guess, gshare_guess, mispredicted,
      input  ready
   );

   modport sink (
      input  valid, command, pc, branch_taken, history_snapshot,
             bimodal_guess, gshare_guess, mispredicted,
      output ready
   );
endinterface

interface tbp_rsp_if
   import tbp_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    predicted_taken;
   logic                    bimodal_taken;
   logic                    gshare_taken;
   logic [HIST_OUT_W-1:0]   history_now;

   modport source (
      output valid, predicted_taken, bimodal_taken, gshare_taken, history_now,
      input  ready
   );

   modport sink (
      input  valid, predicted_taken, bimodal_taken, gshare_taken, history_now,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/tbp_mod_const.sv
// Two-stage remainder by a constant divisor using a reciprocal multiply and one correction.
`default_nettype none

module tbp_mod_const
   import tbp_pkg::*;
#(
   parameter int DIVISOR = BIMODAL_ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic [WORD_W-1:0]              dividend,
   output logic      [$clog2(DIVISOR)-1:0]     remainder
);

   localparam int RECIP_W = WORD_W + 1;
   localparam int PROD_W  = WORD_W + RECIP_W;
   localparam int SHIFT   = 32;
   localparam int IDX_W   = $clog2(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / DIVISOR);
   localparam logic [WORD_W-1:0]  DIV_W = WORD_W'(DIVISOR);

   logic [PROD_W-1:0]        prod_ff;
   logic [WORD_W-1:0]        dvd_ff;
   logic [IDX_W-1:0]         rem_ff;
   logic [PROD_W-SHIFT-1:0]  quot;
   logic [WORD_W-1:0]        back;
   logic [WORD_W-1:0]        diff;
   logic [WORD_W-1:0]        fixed;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(dividend) * PROD_W'(RECIP);
      dvd_ff  <= dividend;
      rem_ff  <= IDX_W'(fixed);
   end

   always_comb begin
      quot  = prod_ff[PROD_W-1:SHIFT];
      back  = WORD_W'(quot) * DIV_W;
      diff  = dvd_ff - back;
      fixed = (diff >= DIV_W) ? diff - DIV_W : diff;
   end

   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: rtl/core/tbp_counter_table.sv
// Table of 2-bit counters with registered read, one write port and a clearing pass after reset.
`default_nettype none

module tbp_counter_table
   import tbp_pkg::*;
#(
   parameter int ENTRIES = BIMODAL_ENTRIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [$clog2(ENTRIES)-1:0]  rd_addr,
   output ctr_type                          rd_data,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0]  wr_addr,
   input  wire ctr_type                     wr_data,
   output logic                             ready
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   ctr_type            mem [ENTRIES];
   ctr_type            rd_ff;
   logic               clearing_ff;
   logic               clearing_in;
   logic [IDX_W-1:0]   clr_idx_ff;
   logic [IDX_W-1:0]   clr_idx_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_idx_ff] <= CTR_INIT;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
   assign ready   = !clearing_ff;

endmodule

`default_nettype wire

// File: rtl/core/tbp_rsp_fifo.sv
// Response queue that decouples the predictor pipeline from the result channel.
`default_nettype none

module tbp_rsp_fifo
   import tbp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rsp_beat_type  push_beat,
   output logic               pop,
   tbp_rsp_if.source          rsp
);

   rsp_beat_type            mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]    wr_ptr_ff;
   logic [RSP_PTR_W-1:0]    rd_ptr_ff;
   logic [OCC_W-1:0]        count_ff;
   logic [OCC_W-1:0]        count_in;
   rsp_beat_type            head;

   assign head      = mem_ff[rd_ptr_ff];
   assign rsp.valid = (count_ff != '0);
   assign pop       = rsp.valid && rsp.ready;

   assign rsp.predicted_taken = head.predicted_taken;
   assign rsp.bimodal_taken   = head.bimodal_taken;
   assign rsp.gshare_taken    = head.gshare_taken;
   assign rsp.history_now     = head.history_now;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tournament_branch_predictor_top.sv
// Top level of the tournament branch predictor: history, index pipeline, tables and responses.
//
//   channel   dir   handshake      beat
//   req_chan  in    valid/ready    command, pc, branch_taken, history_snapshot,
//                                  bimodal_guess, gshare_guess, mispredicted
//   rsp_chan  out   valid/ready    predicted_taken, bimodal_taken, gshare_taken,
//                                  history_now
//
// One beat per cycle in while req ready is high; a request passes the input
// registers, the constant-remainder index units' registers, the table read,
// training and the response queue before its response appears. After reset
// the tables run a clearing pass, with req ready low until the largest of the
// three tables is cleared. An eight-entry response queue absorbs stalls;
// req ready drops once eight beats are in flight or queued.
`default_nettype none

module tournament_branch_predictor_top
   import tbp_pkg::*;
#(
   parameter int BIMODAL_ENTRIES = BIMODAL_ENTRIES_DEF,
   parameter int GSHARE_ENTRIES  = GSHARE_ENTRIES_DEF,
   parameter int CHOOSER_ENTRIES = CHOOSER_ENTRIES_DEF,
   parameter int HISTORY_BITS    = HISTORY_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tbp_req_if.sink    req_chan,
   tbp_rsp_if.source  rsp_chan
);

   localparam int BW    = $clog2(BIMODAL_ENTRIES);
   localparam int GW    = $clog2(GSHARE_ENTRIES);
   localparam int CW    = $clog2(CHOOSER_ENTRIES);
   localparam int SEL_W = (HISTORY_BITS > SNAP_W) ? HISTORY_BITS : SNAP_W;
   localparam int LAST  = PIPE_STAGES - 1;

   logic                      req_accept;
   logic                      rsp_pop;
   logic                      tables_ready;
   logic                      bim_ready;
   logic                      gsh_ready;
   logic                      cho_ready;

   logic [HISTORY_BITS-1:0]   history_ff;
   logic [HISTORY_BITS-1:0]   history_in;
   logic [HISTORY_BITS-1:0]   hist_after;
   logic [SEL_W-1:0]          snap_ext;
   logic [SEL_W-1:0]          hist_ext;
   logic [SEL_W-1:0]          hist_sel;
   logic [SEL_W-1:0]          hist_base;
   logic [SEL_W:0]            hist_shift;
   logic [SEL_W-1:0]          hist_wide;
   logic [WORD_W-1:0]         word;
   item_type                  item_in;

   logic [PIPE_STAGES-1:0]    vld_ff;
   item_type                  item_ff [PIPE_STAGES];
   logic [WORD_W-1:0]         bx_ff;
   logic [WORD_W-1:0]         gx_ff;
   logic [WORD_W-1:0]         cx_ff;

   logic [BW-1:0]             bidx;
   logic [GW-1:0]             gidx;
   logic [CW-1:0]             cidx;
   logic [BW-1:0]             bidx_ff;
   logic [GW-1:0]             gidx_ff;
   logic [CW-1:0]             cidx_ff;

   ctr_type                   bim_rd;
   ctr_type                   gsh_rd;
   ctr_type                   cho_rd;
   logic                      byp_b_ff;
   logic                      byp_g_ff;
   logic                      byp_c_ff;
   ctr_type                   byp_bd_ff;
   ctr_type                   byp_gd_ff;
   ctr_type                   byp_cd_ff;
   ctr_type                   bim_cnt;
   ctr_type                   gsh_cnt;
   ctr_type                   cho_cnt;
   ctr_type                   bim_new;
   ctr_type                   gsh_new;
   ctr_type                   cho_new;
   logic                      bim_ok;
   logic                      gsh_ok;
   logic                      wr_en;
   item_type                  tail;
   rsp_beat_type              push_beat;

   logic [OCC_W-1:0]          occ_ff;
   logic [OCC_W-1:0]          occ_in;

   // Request side: history and index keys
   assign tables_ready   = bim_ready && gsh_ready && cho_ready;
   assign req_chan.ready = tables_ready && (occ_ff < OCC_W'(RSP_DEPTH));
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      word       = req_chan.pc[PC_W-1:2];
      snap_ext   = SEL_W'(req_chan.history_snapshot);
      hist_ext   = SEL_W'(history_ff);
      hist_sel   = (req_chan.command == CMD_UPDATE) ? snap_ext : hist_ext;
      hist_base  = req_chan.mispredicted ? snap_ext : hist_ext;
      hist_shift = {hist_base, req_chan.branch_taken};
      history_in = hist_shift[HISTORY_BITS-1:0];
      hist_after = (req_chan.command == CMD_UPDATE) ? history_in : history_ff;
      hist_wide  = SEL_W'(hist_after);

      item_in.command       = req_chan.command;
      item_in.branch_taken  = req_chan.branch_taken;
      item_in.bimodal_guess = req_chan.bimodal_guess;
      item_in.gshare_guess  = req_chan.gshare_guess;
      item_in.history_now   = hist_wide[HIST_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         vld_ff     <= '0;
      end else begin
         if (req_accept && (req_chan.command == CMD_UPDATE)) begin
            history_ff <= history_in;
         end
         vld_ff <= {vld_ff[PIPE_STAGES-2:0], req_accept};
      end
   end

   always_ff @(posedge clock) begin
      item_ff[0] <= item_in;
      for (int i = 1; i < PIPE_STAGES; i++) begin
         item_ff[i] <= item_ff[i-1];
      end
      bx_ff   <= word;
      gx_ff   <= word ^ WORD_W'(hist_sel);
      cx_ff   <= WORD_W'(hist_sel);
      bidx_ff <= bidx;
      gidx_ff <= gidx;
      cidx_ff <= cidx;
   end

   tbp_mod_const #(.DIVISOR(BIMODAL_ENTRIES)) u_bim_mod (
      .clock     (clock),
      .dividend  (bx_ff),
      .remainder (bidx)
   );

   tbp_mod_const #(.DIVISOR(GSHARE_ENTRIES)) u_gsh_mod (
      .clock     (clock),
      .dividend  (gx_ff),
      .remainder (gidx)
   );

   tbp_mod_const #(.DIVISOR(CHOOSER_ENTRIES)) u_cho_mod (
      .clock     (clock),
      .dividend  (cx_ff),
      .remainder (cidx)
   );

   tbp_counter_table #(.ENTRIES(BIMODAL_ENTRIES)) u_bim_tbl (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (bidx),
      .rd_data (bim_rd),
      .wr_en   (wr_en),
      .wr_addr (bidx_ff),
      .wr_data (bim_new),
      .ready   (bim_ready)
   );

   tbp_counter_table #(.ENTRIES(GSHARE_ENTRIES)) u_gsh_tbl (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (gidx),
      .rd_data (gsh_rd),
      .wr_en   (wr_en),
      .wr_addr (gidx_ff),
      .wr_data (gsh_new),
      .ready   (gsh_ready)
   );

   tbp_counter_table #(.ENTRIES(CHOOSER_ENTRIES)) u_cho_tbl (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (cidx),
      .rd_data (cho_rd),
      .wr_en   (wr_en),
      .wr_addr (cidx_ff),
      .wr_data (cho_new),
      .ready   (cho_ready)
   );

   // Train and respond
   always_comb begin
      tail    = item_ff[LAST];
      wr_en   = vld_ff[LAST] && (tail.command == CMD_UPDATE);
      bim_cnt = byp_b_ff ? byp_bd_ff : bim_rd;
      gsh_cnt = byp_g_ff ? byp_gd_ff : gsh_rd;
      cho_cnt = byp_c_ff ? byp_cd_ff : cho_rd;
      bim_ok  = (tail.bimodal_guess == tail.branch_taken);
      gsh_ok  = (tail.gshare_guess == tail.branch_taken);
      bim_new = tail.branch_taken ? ctr_inc(bim_cnt) : ctr_dec(bim_cnt);
      gsh_new = tail.branch_taken ? ctr_inc(gsh_cnt) : ctr_dec(gsh_cnt);
      if (bim_ok && !gsh_ok) begin
         cho_new = ctr_dec(cho_cnt);
      end else if (!bim_ok && gsh_ok) begin
         cho_new = ctr_inc(cho_cnt);
      end else begin
         cho_new = cho_cnt;
      end

      push_beat.history_now = tail.history_now;
      if (tail.command == CMD_PREDICT) begin
         push_beat.bimodal_taken   = bim_cnt[1];
         push_beat.gshare_taken    = gsh_cnt[1];
         push_beat.predicted_taken = cho_cnt[1] ? gsh_cnt[1] : bim_cnt[1];
      end else begin
         push_beat.bimodal_taken   = 1'b0;
         push_beat.gshare_taken    = 1'b0;
         push_beat.predicted_taken = 1'b0;
      end
   end

   // forward a write landing on the same edge as the read of the next beat
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_b_ff <= 1'b0;
         byp_g_ff <= 1'b0;
         byp_c_ff <= 1'b0;
      end else begin
         byp_b_ff <= wr_en && (bidx_ff == bidx);
         byp_g_ff <= wr_en && (gidx_ff == gidx);
         byp_c_ff <= wr_en && (cidx_ff == cidx);
      end
   end

   always_ff @(posedge clock) begin
      byp_bd_ff <= bim_new;
      byp_gd_ff <= gsh_new;
      byp_cd_ff <= cho_new;
   end

   tbp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (vld_ff[LAST]),
      .push_beat (push_beat),
      .pop       (rsp_pop),
      .rsp       (rsp_chan)
   );

   always_comb begin
      case ({req_accept, rsp_pop})
         2'b10:   occ_in = occ_ff + 1'b1;
         2'b01:   occ_in = occ_ff - 1'b1;
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(RSP_DEPTH))
      else $error("in-flight count above queue depth");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> tables_ready)
      else $error("request accepted during table clearing");

   a_update_zero: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!push_beat.predicted_taken && !push_beat.bimodal_taken
                 && !push_beat.gshare_taken))
      else $error("update beat carries a prediction");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (occ_ff != '0))
      else $error("response shown with nothing in flight");
`endif

endmodule

`default_nettype wire
